// ----- sv/rrla_pkg.sv -----
// Shared types and constants for the rational resampler with interpolation and averaging.
`default_nettype none

package rrla_pkg;

    // Width of the factor registers and of the configuration data.
    localparam int FACTOR_W = 5;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 1;
    // Quotient bits produced per divider iteration.
    localparam int DIGIT_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_UP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_POINT,
        S_FSTART,
        S_FIN,
        S_FLUSH
    } t_state;

    // Commands from the sequencer to each lane.
    typedef struct packed {
        logic load_prev;
        logic load_new;
        logic start_step;
        logic init_pts;
        logic add_point;
        logic start_fin;
        logic clear_sum;
        logic commit_prev;
    } t_lane_ctrl;

    // Commands from the sequencer to the merge stage.
    typedef struct packed {
        logic push;
        logic flush;
    } t_merge_ctrl;

endpackage

`default_nettype wire

// ----- sv/rrla_if.sv -----
// Valid/ready channel interfaces for input samples and averaged results.
`default_nettype none

interface rrla_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;

    modport source (output valid, sample_i, sample_q, input ready);
    modport sink   (input valid, sample_i, sample_q, output ready);
endinterface

interface rrla_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_i;
    logic signed [SAMPLE_BITS-1:0] out_q;
    logic                          last_of_run;

    modport source (output valid, out_i, out_q, last_of_run, input ready);
    modport sink   (input valid, out_i, out_q, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/rrla_div.sv -----
// Radix-16 unsigned divider by a small factor, one quotient digit per cycle.
`default_nettype none

module rrla_div
    import rrla_pkg::*;
#(
    parameter int DW = 38
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DW-1:0]       i_dividend,
    input  wire logic [FACTOR_W-1:0] i_divisor,
    output logic                     o_busy,
    output logic [DW-1:0]            o_quotient
);

    localparam int NDIG = (DW + DIGIT_W - 1) / DIGIT_W;
    localparam int PW   = NDIG * DIGIT_W;
    localparam int CW   = $clog2(NDIG + 1);
    localparam int VW   = FACTOR_W + DIGIT_W;

    logic [PW-1:0]       r_dvd;
    logic [PW-1:0]       r_quo;
    logic [FACTOR_W-1:0] r_rem;
    logic [FACTOR_W-1:0] r_dsr;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic [VW-1:0]       val;
    logic [VW-1:0]       prod;
    logic [DIGIT_W-1:0]  digit;
    logic [FACTOR_W-1:0] n_rem;

    // Digit selection: the partial remainder stays below the divisor, so the
    // shifted-in value is below sixteen times the divisor.
    always_comb begin
        val   = {r_rem, r_dvd[PW-1 -: DIGIT_W]};
        digit = '0;
        for (int k = 1; k < 2**DIGIT_W; k++) begin
            if (VW'(k) * VW'(r_dsr) <= val) begin
                digit = DIGIT_W'(k);
            end
        end
        prod  = VW'(digit) * VW'(r_dsr);
        n_rem = FACTOR_W'(val - prod);
    end

    // Iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NDIG);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    // Datapath: shift the dividend out and the quotient in, one digit at a time.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= PW'(i_dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= r_dvd << DIGIT_W;
            r_quo <= (r_quo << DIGIT_W) | PW'(digit);
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo[DW-1:0];

endmodule

`default_nettype wire

// ----- sv/rrla_lane.sv -----
// One component lane: step division, point generation, accumulation and averaging.
`default_nettype none

module rrla_lane
    import rrla_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16,
    parameter int SUM_W       = 38
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_lane_ctrl                    i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [FACTOR_W-1:0]           i_up,
    input  wire logic [FACTOR_W-1:0]           i_down,
    output logic                               o_busy,
    output logic signed [SAMPLE_BITS-1:0]      o_result
);

    localparam int PT_W = SAMPLE_BITS + FRAC_BITS + 1;
    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'((2**(SAMPLE_BITS-1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI - 1;

    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [SAMPLE_BITS-1:0] r_new;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]          diff_mag;
    logic                          r_step_neg;
    logic                          r_fin_neg;
    logic signed [PT_W-1:0]        r_step;
    logic signed [PT_W-1:0]        r_pt;
    logic signed [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]              sum_mag;
    logic [SUM_W-1:0]              div_in;
    logic [SUM_W-1:0]              quo;
    logic [FACTOR_W-1:0]           div_d;
    logic                          div_start;
    logic signed [SUM_W:0]         q_signed;
    logic signed [SUM_W:0]         q_shift;

    // Difference between the arriving sample and the previous one, as sign and magnitude.
    assign diff     = (SAMPLE_BITS+1)'(i_sample) - (SAMPLE_BITS+1)'(r_prev);
    assign diff_mag = diff[SAMPLE_BITS] ? $unsigned(-diff) : $unsigned(diff);
    assign sum_mag  = r_sum[SUM_W-1] ? $unsigned(-r_sum) : $unsigned(r_sum);

    // The shared divider serves both the step and the group average.
    assign div_start = i_ctrl.start_step | i_ctrl.start_fin;
    assign div_in    = i_ctrl.start_fin ? sum_mag
                                        : SUM_W'({diff_mag, {FRAC_BITS{1'b0}}});
    assign div_d     = i_ctrl.start_fin ? i_down : i_up;

    rrla_div #(
        .DW (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  (div_d),
        .o_busy     (o_busy),
        .o_quotient (quo)
    );

    // Sample history and sign flags.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_prev) begin
            r_prev <= i_sample;
        end else if (i_ctrl.commit_prev) begin
            r_prev <= r_new;
        end
        if (i_ctrl.load_new) begin
            r_new <= i_sample;
        end
        if (i_ctrl.start_step) begin
            r_step_neg <= diff[SAMPLE_BITS];
        end
        if (i_ctrl.start_fin) begin
            r_fin_neg <= r_sum[SUM_W-1];
        end
    end

    // Interpolated point walks from the previous sample by the truncated step.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init_pts) begin
            r_step <= r_step_neg ? -$signed(PT_W'(quo)) : $signed(PT_W'(quo));
            r_pt   <= PT_W'(r_prev) <<< FRAC_BITS;
        end else if (i_ctrl.add_point) begin
            r_pt   <= r_pt + r_step;
        end
    end

    // Running group sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.clear_sum) begin
            r_sum <= '0;
        end else if (i_ctrl.add_point) begin
            r_sum <= r_sum + SUM_W'(r_pt);
        end
    end

    // Signed average, floor shift out of fixed point, then saturation.
    always_comb begin
        q_signed = r_fin_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        q_shift  = q_signed >>> FRAC_BITS;
        if (q_shift > SAT_HI) begin
            o_result = $signed(SAT_HI[SAMPLE_BITS-1:0]);
        end else if (q_shift < SAT_LO) begin
            o_result = $signed(SAT_LO[SAMPLE_BITS-1:0]);
        end else begin
            o_result = $signed(q_shift[SAMPLE_BITS-1:0]);
        end
    end

endmodule

`default_nettype wire

// ----- sv/rrla_merge.sv -----
// Merge stage: pairs the lane results, marks the last one of a sample, drives the output.
`default_nettype none

module rrla_merge
    import rrla_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_merge_ctrl                   i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_res_i,
    input  wire logic signed [SAMPLE_BITS-1:0] i_res_q,
    output logic                               o_ok,
    rrla_out_if.source                         o_res
);

    logic                          r_pend_v;
    logic                          r_out_v;
    logic                          r_last;
    logic signed [SAMPLE_BITS-1:0] r_pend_i;
    logic signed [SAMPLE_BITS-1:0] r_pend_q;
    logic signed [SAMPLE_BITS-1:0] r_out_i;
    logic signed [SAMPLE_BITS-1:0] r_out_q;
    logic                          take;
    logic                          move;

    // A result is held back until it is known whether another follows from the
    // same sample; it moves to the output register on the next push or on flush.
    assign take = r_out_v && o_res.ready;
    assign move = (i_ctrl.push || i_ctrl.flush) && r_pend_v;
    assign o_ok = !r_pend_v || !r_out_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (move) begin
                r_out_v <= 1'b1;
            end else if (take) begin
                r_out_v <= 1'b0;
            end
            if (i_ctrl.push) begin
                r_pend_v <= 1'b1;
            end else if (i_ctrl.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_i <= r_pend_i;
            r_out_q <= r_pend_q;
            r_last  <= i_ctrl.flush;
        end
        if (i_ctrl.push) begin
            r_pend_i <= i_res_i;
            r_pend_q <= i_res_q;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.out_i       = r_out_i;
    assign o_res.out_q       = r_out_q;
    assign o_res.last_of_run = r_last;

endmodule

`default_nettype wire

// ----- sv/rational_resampler_lerp_average_unit.sv -----
// Top level of the rational resampler: sequencer, I and Q lanes and merge stage.
`default_nettype none

// Complex samples enter on i_smp; each one after the first yields up_factor linearly
// interpolated Q.FRAC_BITS points, and every down_factor points give one averaged,
// saturated result on o_res, with last_of_run set on the final result of a sample.
// The first sample after reset only primes the block. Both the step and every group
// average go through a radix-16 divider in each lane, one quotient digit per cycle,
// and points are summed one per cycle; that divider and the point loop set the rate.
// A new sample is taken once the previous one is fully processed, while its last
// result may still wait in the output register.
module rational_resampler_lerp_average_unit
    import rrla_pkg::*;
#(
    parameter int MAX_FACTOR  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FACTOR_W-1:0]  i_cfg_data,
    rrla_in_if.sink                   i_smp,
    rrla_out_if.source                o_res
);

    localparam int SUM_W = SAMPLE_BITS + FRAC_BITS + 6;

    t_state                        r_state;
    t_state                        n_state;
    logic                          r_primed;
    logic                          n_primed;
    logic [FACTOR_W-1:0]           r_up;
    logic [FACTOR_W-1:0]           r_down;
    logic [FACTOR_W-1:0]           r_cnt;
    logic [FACTOR_W-1:0]           n_cnt;
    logic [FACTOR_W-1:0]           r_k;
    logic [FACTOR_W-1:0]           n_k;
    logic [FACTOR_W-1:0]           up_eff;
    logic [FACTOR_W-1:0]           down_eff;
    logic                          acc;
    logic                          busy_i;
    logic                          busy_q;
    logic                          busy;
    logic                          merge_ok;
    t_lane_ctrl                    lane_ctrl;
    t_merge_ctrl                   merge_ctrl;
    logic signed [SAMPLE_BITS-1:0] res_i;
    logic signed [SAMPLE_BITS-1:0] res_q;

    // Zero acts as one and values above the maximum are clamped.
    function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        if (f == '0) begin
            r = FACTOR_W'(1);
        end else if (int'(f) > MAX_FACTOR) begin
            r = FACTOR_W'(MAX_FACTOR);
        end else begin
            r = f;
        end
        return r;
    endfunction

    assign up_eff   = eff_factor(r_up);
    assign down_eff = eff_factor(r_down);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up   <= FACTOR_W'(1);
            r_down <= FACTOR_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_UP) begin
                r_up <= i_cfg_data;
            end else if (i_cfg_idx == REG_DOWN) begin
                r_down <= i_cfg_data;
            end
        end
    end

    assign i_smp.ready = (r_state == S_IDLE);
    assign acc         = i_smp.valid && i_smp.ready;
    assign busy        = busy_i | busy_q;

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
            r_cnt    <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_primed <= n_primed;
            r_cnt    <= n_cnt;
            r_k      <= n_k;
        end
    end

    // Sequencer next state and lane commands.
    always_comb begin
        n_state    = r_state;
        n_primed   = r_primed;
        n_cnt      = r_cnt;
        n_k        = r_k;
        lane_ctrl  = '0;
        merge_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (!r_primed) begin
                        lane_ctrl.load_prev = 1'b1;
                        n_primed            = 1'b1;
                    end else begin
                        lane_ctrl.load_new   = 1'b1;
                        lane_ctrl.start_step = 1'b1;
                        n_state              = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (!busy) begin
                    lane_ctrl.init_pts = 1'b1;
                    n_k                = '0;
                    n_state            = S_POINT;
                end
            end
            S_POINT: begin
                lane_ctrl.add_point = 1'b1;
                n_k                 = r_k + 1'b1;
                n_cnt               = r_cnt + 1'b1;
                if (n_cnt >= down_eff) begin
                    n_state = S_FSTART;
                end else if (n_k == up_eff) begin
                    n_state = S_FLUSH;
                end
            end
            S_FSTART: begin
                lane_ctrl.start_fin = 1'b1;
                n_state             = S_FIN;
            end
            S_FIN: begin
                if (!busy && merge_ok) begin
                    merge_ctrl.push     = 1'b1;
                    lane_ctrl.clear_sum = 1'b1;
                    n_cnt               = '0;
                    n_state             = (r_k == up_eff) ? S_FLUSH : S_POINT;
                end
            end
            S_FLUSH: begin
                if (merge_ok) begin
                    merge_ctrl.flush      = 1'b1;
                    lane_ctrl.commit_prev = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // In-phase and quadrature lanes.
    rrla_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .SUM_W       (SUM_W)
    ) u_lane_i (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (lane_ctrl),
        .i_sample (i_smp.sample_i),
        .i_up     (up_eff),
        .i_down   (down_eff),
        .o_busy   (busy_i),
        .o_result (res_i)
    );

    rrla_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .SUM_W       (SUM_W)
    ) u_lane_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (lane_ctrl),
        .i_sample (i_smp.sample_q),
        .i_up     (up_eff),
        .i_down   (down_eff),
        .o_busy   (busy_q),
        .o_result (res_q)
    );

    // Merge of the lane results into output transactions.
    rrla_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (merge_ctrl),
        .i_res_i (res_i),
        .i_res_q (res_q),
        .o_ok    (merge_ok),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // The dividers are idle whenever a new sample can be taken.
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !busy)
        else $error("divider busy while waiting for a sample");

    // The point loop never runs past the interpolation factor.
    a_point_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POINT) |-> (r_k < up_eff))
        else $error("point index beyond interpolation factor");

    // A priming sample leaves the sequencer idle and marks the block primed.
    a_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !r_primed) |=> (r_state == S_IDLE) && r_primed)
        else $error("priming sample started processing");
`endif

endmodule

`default_nettype wire
